/* rtl/tqpb_pkg.sv */
// ----------------------------------------------------------------------------
// tqpb_pkg
// Shared types, constants and arithmetic helpers of the textured quad pixel
// blend block.
// ----------------------------------------------------------------------------
package tqpb_pkg;

  localparam int unsigned TEX_WIDTH_DEF  = 64;
  localparam int unsigned TEX_HEIGHT_DEF = 64;
  localparam int unsigned FIFO_DEPTH_DEF = 4;

  localparam int unsigned STORE_AW    = 12;
  localparam int unsigned STORE_DEPTH = 1 << STORE_AW;
  localparam int unsigned CFG_IW      = 4;
  localparam int unsigned CFG_DW      = 48;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ORIGIN_X   = 4'd0,
    CFG_ORIGIN_Y   = 4'd1,
    CFG_U_STEP_X   = 4'd2,
    CFG_U_STEP_Y   = 4'd3,
    CFG_V_STEP_X   = 4'd4,
    CFG_V_STEP_Y   = 4'd5,
    CFG_TINT_RGB   = 4'd6,
    CFG_TINT_ALPHA = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [23:0] origin_x;
    logic signed [23:0] orig_y;
    logic signed [31:0] u_step_x;
    logic signed [31:0] u_step_y;
    logic signed [31:0] v_step_x;
    logic signed [31:0] v_step_y;
  } geom_cfg_t;

  typedef struct packed {
    logic [47:0] rgb;
    logic [15:0] alpha;
  } tint_cfg_t;

  // one classified item between the front and the back
  typedef struct packed {
    logic                         is_write;
    logic                         covered;
    logic [31:0]                  dest;
    logic [15:0]                  fu;
    logic [15:0]                  fv;
    logic [3:0][STORE_AW-1:0]     addr;
    logic [31:0]                  wdata;
  } tex_item_t;

  // blended linear values, index 0 alpha, 1 r, 2 g, 3 b
  typedef struct packed {
    logic             covered;
    logic [31:0]      dest;
    logic [3:0][16:0] b;
  } blend_t;

  typedef struct packed {
    logic        covered;
    logic [31:0] pixel;
  } srgb_res_t;

  // srgb byte to linear q0.16, squared approximation
  function automatic logic [255:0][15:0] build_lin_lut();
    logic [255:0][15:0] lut;
    logic [63:0]        p;
    int                 i;
    for (i = 0; i < 256; i++) begin
      p = 64'(i) * 64'(i) * 64'd65535 + 64'd32512;
      lut[i] = 16'(p / 64'd65025);
    end
    return lut;
  endfunction

  localparam logic [255:0][15:0] LIN_LUT = build_lin_lut();

  // floor(x / 65535) by reciprocal estimate and correction
  function automatic logic [17:0] div65535(input logic [33:0] x);
    logic [34:0] s;
    logic [18:0] est;
    logic [34:0] prod;
    logic [34:0] r;
    s    = 35'(x) + 35'(x >> 16);
    est  = s[34:16];
    prod = (35'(est) << 16) - 35'(est);
    r    = 35'(x) - prod;
    if (r >= 35'd131070) begin
      est = est + 19'd2;
    end else if (r >= 35'd65535) begin
      est = est + 19'd1;
    end
    return est[17:0];
  endfunction

endpackage

/* rtl/tqpb_if.sv */
// ----------------------------------------------------------------------------
// tqpb channel interfaces
// Pixel request, pixel result and configuration write channels.
// ----------------------------------------------------------------------------
interface tqpb_pix_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [11:0] screen_x;
  logic [11:0] screen_y;
  logic [31:0] dest_pixel;
  logic [11:0] texel_index;
  logic [31:0] texel_value;

  modport source (output valid, req_type, screen_x, screen_y, dest_pixel,
                  texel_index, texel_value, input ready);
  modport sink (input valid, req_type, screen_x, screen_y, dest_pixel,
                texel_index, texel_value, output ready);
endinterface

interface tqpb_pix_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;
  logic        covered;

  modport source (output valid, out_pixel, covered, input ready);
  modport sink (input valid, out_pixel, covered, output ready);
endinterface

interface tqpb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tqpb_pkg::CFG_IW-1:0]  index;
  logic [tqpb_pkg::CFG_DW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/tqpb_front.sv */
// ----------------------------------------------------------------------------
// tqpb_front
// Accepts items, maps shade positions to quad coordinates, tests coverage
// and forms the four texel addresses and the bilinear fractions.
// ----------------------------------------------------------------------------
module tqpb_front #(
  parameter int unsigned TEX_WIDTH  = tqpb_pkg::TEX_WIDTH_DEF,
  parameter int unsigned TEX_HEIGHT = tqpb_pkg::TEX_HEIGHT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tqpb_pix_in_if.sink         in_chan_i,
  input  tqpb_pkg::geom_cfg_t geom_i,
  output logic                push_valid_o,
  output tqpb_pkg::tex_item_t push_data_o,
  input  logic                push_ready_i
);

  localparam int unsigned AW  = tqpb_pkg::STORE_AW;
  localparam int unsigned TuW = 33 + $clog2(TEX_WIDTH - 1);
  localparam int unsigned TvW = 33 + $clog2(TEX_HEIGHT - 1);
  localparam logic [AW-1:0] TexW = AW'(TEX_WIDTH);

  typedef struct packed {
    logic        is_write;
    logic [31:0] dest;
    logic [11:0] tidx;
    logic [31:0] tval;
  } carry_t;

  logic               adv;
  logic [4:1]         vld_q;
  carry_t [4:1]       car_q;
  logic signed [25:0] dx1_q, dy1_q;
  logic signed [25:0] dx_d, dy_d;
  logic signed [57:0] pux2_q, puy2_q, pvx2_q, pvy2_q;
  logic signed [58:0] u3_q, v3_q;
  logic               cov_d, cov4_q;
  logic [TuW-1:0]     tu4_q;
  logic [TvW-1:0]     tv4_q;
  logic [AW-1:0]      col, row, base;

  assign adv             = !vld_q[4] || push_ready_i;
  assign in_chan_i.ready = adv;

  assign dx_d = $signed({6'b0, in_chan_i.screen_x, 8'b0}) - 26'(geom_i.origin_x);
  assign dy_d = $signed({6'b0, in_chan_i.screen_y, 8'b0}) - 26'(geom_i.orig_y);

  // 0 <= u <= 1 and 0 <= v < 1 in q.32
  assign cov_d = !u3_q[58] && ((u3_q[57:32] == '0) || (u3_q[57:0] == 58'h1_0000_0000))
                 && !v3_q[58] && (v3_q[57:32] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[3:1], in_chan_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      car_q[1] <= '{is_write: in_chan_i.req_type, dest: in_chan_i.dest_pixel,
                    tidx: in_chan_i.texel_index, tval: in_chan_i.texel_value};
      car_q[4:2] <= car_q[3:1];
      dx1_q  <= dx_d;
      dy1_q  <= dy_d;
      pux2_q <= dx1_q * geom_i.u_step_x;
      puy2_q <= dy1_q * geom_i.u_step_y;
      pvx2_q <= dx1_q * geom_i.v_step_x;
      pvy2_q <= dy1_q * geom_i.v_step_y;
      u3_q   <= 59'(pux2_q) + 59'(puy2_q);
      v3_q   <= 59'(pvx2_q) + 59'(pvy2_q);
      cov4_q <= cov_d;
      tu4_q  <= TuW'(u3_q[32:0]) * TuW'(TEX_WIDTH - 2);
      tv4_q  <= TvW'(v3_q[32:0]) * TvW'(TEX_HEIGHT - 2);
    end
  end

  assign col  = AW'(tu4_q >> 32);
  assign row  = AW'(tv4_q >> 32);
  assign base = row * TexW + col;

  always_comb begin
    push_data_o.is_write = car_q[4].is_write;
    push_data_o.covered  = cov4_q;
    push_data_o.dest     = car_q[4].dest;
    push_data_o.fu       = tu4_q[31:16];
    push_data_o.fv       = tv4_q[31:16];
    // a texel write carries its store address in slot zero
    push_data_o.addr[0]  = car_q[4].is_write ? car_q[4].tidx : base;
    push_data_o.addr[1]  = base + AW'(1);
    push_data_o.addr[2]  = base + TexW;
    push_data_o.addr[3]  = base + TexW + AW'(1);
    push_data_o.wdata    = car_q[4].tval;
  end

  assign push_valid_o = vld_q[4];

endmodule

/* rtl/tqpb_fifo.sv */
// ----------------------------------------------------------------------------
// tqpb_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module tqpb_fifo #(
  parameter int unsigned DEPTH = tqpb_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  tqpb_pkg::tex_item_t push_data_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output tqpb_pkg::tex_item_t pop_data_o,
  input  logic                pop_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tqpb_pkg::tex_item_t slot_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue count above depth");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_q) + CW'($past(do_push)) - CW'($past(do_pop)))
    else $error("queue count lost track of pushes and pops");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> pop_valid_o)
    else $error("pop from empty queue");

endmodule

/* rtl/tqpb_srgb.sv */
// ----------------------------------------------------------------------------
// tqpb_srgb
// Converts blended linear values back to bytes: square root of rgb found
// one result bit per stage, alpha scaled with rounding.
// ----------------------------------------------------------------------------
module tqpb_srgb (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  tqpb_pkg::blend_t    blend_i,
  output logic                valid_o,
  output tqpb_pkg::srgb_res_t res_o
);

  localparam int unsigned Steps = 8;

  logic [Steps:0]                sv_q;
  logic [Steps:0]                cov_q;
  logic [Steps:0][31:0]          dest_q;
  logic [Steps:0][7:0]           a_q;
  logic [Steps:0][2:0][35:0]     q_q;
  logic [Steps:0][2:0][7:0]      r_q;
  logic [Steps:1][2:0][7:0]      nr;
  logic [26:0]                   ax;
  logic [17:0]                   an;
  logic [7:0]                    a_d;

  assign ax  = 27'(blend_i.b[0]) * 27'd510 + 27'd65535;
  assign an  = tqpb_pkg::div65535(34'(ax >> 1));
  assign a_d = (an > 18'd255) ? 8'd255 : an[7:0];

  // keep the trial bit when (2n-1)^2 * 65535 <= 4 * 65025 * b
  always_comb begin
    logic [7:0]  trial;
    logic [8:0]  h;
    logic [17:0] h2;
    logic [33:0] lhs;
    for (int s = 1; s <= Steps; s++) begin
      for (int c = 0; c < 3; c++) begin
        trial = r_q[s-1][c] | (8'd1 << (Steps - s));
        h     = {trial, 1'b0} - 9'd1;
        h2    = 18'(h) * 18'(h);
        lhs   = (34'(h2) << 16) - 34'(h2);
        nr[s][c] = (36'(lhs) <= q_q[s-1][c]) ? trial : r_q[s-1][c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (en_i) begin
      sv_q <= {sv_q[Steps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cov_q[0]  <= blend_i.covered;
      dest_q[0] <= blend_i.dest;
      a_q[0]    <= a_d;
      for (int c = 0; c < 3; c++) begin
        q_q[0][c] <= 36'(blend_i.b[c+1]) * 36'd260100;
        r_q[0][c] <= '0;
      end
      for (int s = 1; s <= Steps; s++) begin
        cov_q[s]  <= cov_q[s-1];
        dest_q[s] <= dest_q[s-1];
        a_q[s]    <= a_q[s-1];
        q_q[s]    <= q_q[s-1];
        r_q[s]    <= nr[s];
      end
    end
  end

  assign valid_o       = sv_q[Steps];
  assign res_o.covered = cov_q[Steps];
  assign res_o.pixel   = cov_q[Steps]
                       ? {a_q[Steps], r_q[Steps][0], r_q[Steps][1], r_q[Steps][2]}
                       : dest_q[Steps];

endmodule

/* rtl/tqpb_back.sv */
// ----------------------------------------------------------------------------
// tqpb_back
// Texture store, bilinear sample, tint, blend over the destination and
// byte conversion, with the result register.
// ----------------------------------------------------------------------------
module tqpb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  input  tqpb_pkg::tex_item_t pop_data_i,
  output logic                pop_o,
  input  tqpb_pkg::tint_cfg_t tint_i,
  tqpb_pix_out_if.source      out_chan_o
);

  typedef struct packed {
    logic        covered;
    logic [31:0] dest;
  } meta_t;

  logic                   adv;
  logic                   out_valid_q;
  tqpb_pkg::srgb_res_t    out_q;
  logic                   sr_valid;
  tqpb_pkg::srgb_res_t    sr_res;

  logic [31:0]            mem [4][tqpb_pkg::STORE_DEPTH];
  logic [3:0][31:0]       texel_q;
  logic [8:1]             vld_q;
  meta_t [7:1]            meta_q;
  logic [15:0]            fu1_q, fv1_q;
  logic [16:0]            omu, omv;
  logic [3:0][32:0]       w2_q;
  logic [3:0][3:0][15:0]  tl2_q;
  logic [3:0][3:0][48:0]  p3_q;
  logic [3:0][15:0]       t4_q;
  logic [3:0][31:0]       tp5_q;
  logic [3:0][15:0]       dl5_q, dl6_q;
  logic [3:0][15:0]       tt6_q, tt7_q;
  logic [3:0][31:0]       bp7_q;
  logic [3:0][15:0]       kt;
  logic [3:0][50:0]       sum4;
  tqpb_pkg::blend_t       b8_q;

  // linear channels of one pixel, index 0 alpha, 1 r, 2 g, 3 b
  function automatic logic [3:0][15:0] lin_px(input logic [31:0] px);
    logic [3:0][15:0] l;
    l[0] = {px[31:24], px[31:24]};
    l[1] = tqpb_pkg::LIN_LUT[px[23:16]];
    l[2] = tqpb_pkg::LIN_LUT[px[15:8]];
    l[3] = tqpb_pkg::LIN_LUT[px[7:0]];
    return l;
  endfunction

  assign adv   = !out_valid_q || out_chan_o.ready;
  assign pop_o = adv && pop_valid_i;

  assign omu = 17'd65536 - 17'(fu1_q);
  assign omv = 17'd65536 - 17'(fv1_q);

  assign kt[0] = tint_i.alpha;
  assign kt[1] = tint_i.rgb[47:32];
  assign kt[2] = tint_i.rgb[31:16];
  assign kt[3] = tint_i.rgb[15:0];

  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      sum4[ch] = 51'(p3_q[ch][0]) + 51'(p3_q[ch][1]) + 51'(p3_q[ch][2])
               + 51'(p3_q[ch][3]) + 51'h8000_0000;
    end
  end

  // four copies of the store, one read port each for the four neighbors
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int k = 0; k < 4; k++) begin
        if (pop_data_i.is_write) begin
          mem[k][pop_data_i.addr[0]] <= pop_data_i.wdata;
        end
        texel_q[k] <= mem[k][pop_data_i.addr[k]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[7:1], pop_valid_i && !pop_data_i.is_write};
      out_valid_q <= sr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q[1]   <= '{covered: pop_data_i.covered, dest: pop_data_i.dest};
      meta_q[7:2] <= meta_q[6:1];
      fu1_q <= pop_data_i.fu;
      fv1_q <= pop_data_i.fv;
      w2_q[0] <= 33'(omu) * 33'(omv);
      w2_q[1] <= 33'(fu1_q) * 33'(omv);
      w2_q[2] <= 33'(omu) * 33'(fv1_q);
      w2_q[3] <= 33'(fu1_q) * 33'(fv1_q);
      for (int k = 0; k < 4; k++) begin
        tl2_q[k] <= lin_px(texel_q[k]);
      end
      for (int ch = 0; ch < 4; ch++) begin
        for (int k = 0; k < 4; k++) begin
          p3_q[ch][k] <= 49'(w2_q[k]) * 49'(tl2_q[k][ch]);
        end
        t4_q[ch]  <= sum4[ch][47:32];
        tp5_q[ch] <= 32'(t4_q[ch]) * 32'(kt[ch]);
        tt6_q[ch] <= 16'(tqpb_pkg::div65535(34'(tp5_q[ch]) + 34'd32767));
        bp7_q[ch] <= 32'(16'hFFFF - tt6_q[0]) * 32'(dl6_q[ch]);
        b8_q.b[ch] <= 17'(tqpb_pkg::div65535(34'(bp7_q[ch]) + 34'd32767))
                    + 17'(tt7_q[ch]);
      end
      dl5_q        <= lin_px(meta_q[4].dest);
      dl6_q        <= dl5_q;
      tt7_q        <= tt6_q;
      b8_q.covered <= meta_q[7].covered;
      b8_q.dest    <= meta_q[7].dest;
      out_q        <= sr_res;
    end
  end

  tqpb_srgb u_srgb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vld_q[8]),
    .blend_i (b8_q),
    .valid_o (sr_valid),
    .res_o   (sr_res)
  );

  assign out_chan_o.valid     = out_valid_q;
  assign out_chan_o.out_pixel = out_q.pixel;
  assign out_chan_o.covered   = out_q.covered;

endmodule

/* rtl/textured_quad_pixel_blend.sv */
// ----------------------------------------------------------------------------
// textured_quad_pixel_blend
// Textured quad pixel shader: bilinear texture sample, tint and
// premultiplied alpha blend over the destination pixel.
// ----------------------------------------------------------------------------
// One item is taken every clock while the output accepts results, shade and
// texel write alike; the rate is set by the texture store, kept as four copies
// so the four bilinear neighbors are read through four ports in the same cycle.
// A shade result passes through 4 front stages, one queue slot, 8 sample and
// blend stages, 9 square root stages and the output register.
// Texel writes take effect in order with shade items and give no result.
// Texture entries come up undefined after reset and must be written before
// they are sampled. Configuration writes are accepted every cycle.
module textured_quad_pixel_blend #(
  parameter int unsigned TEX_WIDTH  = tqpb_pkg::TEX_WIDTH_DEF,
  parameter int unsigned TEX_HEIGHT = tqpb_pkg::TEX_HEIGHT_DEF,
  parameter int unsigned FIFO_DEPTH = tqpb_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tqpb_pix_in_if.sink     in_chan_i,
  tqpb_pix_out_if.source  out_chan_o,
  tqpb_cfg_if.sink        cfg_chan_i
);

  tqpb_pkg::geom_cfg_t geom_q;
  tqpb_pkg::tint_cfg_t tint_q;
  logic                push_valid, push_ready, pop_valid, pop;
  tqpb_pkg::tex_item_t push_data, pop_data;

  assign cfg_chan_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q       <= '0;
      tint_q.rgb   <= '1;
      tint_q.alpha <= '1;
    end else if (cfg_chan_i.valid) begin
      unique case (cfg_chan_i.index)
        tqpb_pkg::CFG_ORIGIN_X:   geom_q.origin_x <= cfg_chan_i.data[23:0];
        tqpb_pkg::CFG_ORIGIN_Y:   geom_q.orig_y   <= cfg_chan_i.data[23:0];
        tqpb_pkg::CFG_U_STEP_X:   geom_q.u_step_x <= cfg_chan_i.data[31:0];
        tqpb_pkg::CFG_U_STEP_Y:   geom_q.u_step_y <= cfg_chan_i.data[31:0];
        tqpb_pkg::CFG_V_STEP_X:   geom_q.v_step_x <= cfg_chan_i.data[31:0];
        tqpb_pkg::CFG_V_STEP_Y:   geom_q.v_step_y <= cfg_chan_i.data[31:0];
        tqpb_pkg::CFG_TINT_RGB:   tint_q.rgb      <= cfg_chan_i.data[47:0];
        tqpb_pkg::CFG_TINT_ALPHA: tint_q.alpha    <= cfg_chan_i.data[15:0];
        default: ;
      endcase
    end
  end

  tqpb_front #(
    .TEX_WIDTH  (TEX_WIDTH),
    .TEX_HEIGHT (TEX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_chan_i    (in_chan_i),
    .geom_i       (geom_q),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  tqpb_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_i        (pop)
  );

  tqpb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .tint_i      (tint_q),
    .out_chan_o  (out_chan_o)
  );

endmodule

/* bench/tqpb_checker.sv */
// ----------------------------------------------------------------------------
// tqpb_checker
// Watches the request, result and configuration channels of the textured
// quad pixel blend block. It keeps its own copy of the texture and the
// registers and works out each shade result. Each result that arrives is
// compared with the oldest predicted one.
// ----------------------------------------------------------------------------
module tqpb_checker #(
  parameter int unsigned TW = 64,
  parameter int unsigned TH = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  tqpb_pix_in_if  in_mon,
  tqpb_pix_out_if out_mon,
  tqpb_cfg_if     cfg_mon,
  output int      fail_count_o,
  output int      pending_o
);

  typedef struct {
    logic [31:0] pixel;
    logic        covered;
  } shade_res_t;

  logic [31:0]        tex_mem [tqpb_pkg::STORE_DEPTH];
  logic signed [23:0] org_x, org_y;
  logic signed [31:0] ustep_x, ustep_y, vstep_x, vstep_y;
  logic [47:0]        tint_c;
  logic [15:0]        tint_a;
  shade_res_t         shade_q [$];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = shade_q.size();

  function automatic longint unsigned byte_to_lin(logic [7:0] c, bit is_alpha);
    longint unsigned cc;
    cc = c;
    if (is_alpha) return cc * 257;
    return (cc * cc * 65535 + 32512) / 65025;
  endfunction

  function automatic logic [7:0] lin_to_srgb(longint unsigned b);
    longint unsigned q, h;
    logic [7:0]      r;
    r = 0;
    q = 4 * 65025 * b;
    for (int n = 1; n <= 255; n++) begin
      h = 2 * n - 1;
      if (h * h * 65535 <= q) r = 8'(n);
    end
    return r;
  endfunction

  function automatic shade_res_t shade(logic [11:0] sx, logic [11:0] sy, logic [31:0] dest);
    shade_res_t      r;
    longint          dx, dy, u, v;
    longint unsigned tu, tv, fu, fv, base, acc, d, tc, b, av;
    longint unsigned w [4];
    longint unsigned t [4];
    longint unsigned k [4];
    logic [31:0]     s [4];
    r.pixel   = dest;
    r.covered = 1'b0;
    dx = longint'({sx, 8'd0}) - longint'(org_x);
    dy = longint'({sy, 8'd0}) - longint'(org_y);
    u  = dx * longint'(ustep_x) + dy * longint'(ustep_y);
    v  = dx * longint'(vstep_x) + dy * longint'(vstep_y);
    if (!(u >= 0 && u <= (64'sd1 <<< 32) && v >= 0 && v < (64'sd1 <<< 32))) return r;
    tu   = longint'(u) * (TW - 2);
    tv   = longint'(v) * (TH - 2);
    fu   = (tu >> 16) & 16'hFFFF;
    fv   = (tv >> 16) & 16'hFFFF;
    base = (tv >> 32) * TW + (tu >> 32);
    s[0] = tex_mem[base % tqpb_pkg::STORE_DEPTH];
    s[1] = tex_mem[(base + 1) % tqpb_pkg::STORE_DEPTH];
    s[2] = tex_mem[(base + TW) % tqpb_pkg::STORE_DEPTH];
    s[3] = tex_mem[(base + TW + 1) % tqpb_pkg::STORE_DEPTH];
    w[0] = (65536 - fu) * (65536 - fv);
    w[1] = fu * (65536 - fv);
    w[2] = (65536 - fu) * fv;
    w[3] = fu * fv;
    // channel 0 alpha, then r, g, b
    for (int ch = 0; ch < 4; ch++) begin
      acc = 64'd1 << 31;
      for (int i = 0; i < 4; i++) acc += w[i] * byte_to_lin(s[i][31-8*ch -: 8], ch == 0);
      t[ch] = acc >> 32;
    end
    k[0] = tint_a;
    k[1] = tint_c[47:32];
    k[2] = tint_c[31:16];
    k[3] = tint_c[15:0];
    for (int ch = 0; ch < 4; ch++) t[ch] = (t[ch] * k[ch] + 32767) / 65535;
    for (int ch = 0; ch < 4; ch++) begin
      d  = byte_to_lin(dest[31-8*ch -: 8], ch == 0);
      tc = t[ch];
      if (ch != 0 && tc > 65535) tc = 65535;
      b = ((65535 - t[0]) * d + 32767) / 65535 + tc;
      if (ch == 0) begin
        av = (b * 510 + 65535) / 131070;
        r.pixel[31:24] = (av > 255) ? 8'hFF : 8'(av);
      end else begin
        r.pixel[31-8*ch -: 8] = lin_to_srgb(b);
      end
    end
    r.covered = 1'b1;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x   <= '0;
      org_y   <= '0;
      ustep_x <= '0;
      ustep_y <= '0;
      vstep_x <= '0;
      vstep_y <= '0;
      tint_c  <= '1;
      tint_a  <= '1;
      fails   = 0;
      shade_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (tqpb_pkg::cfg_idx_e'(cfg_mon.index))
          tqpb_pkg::CFG_ORIGIN_X:   org_x   <= cfg_mon.data[23:0];
          tqpb_pkg::CFG_ORIGIN_Y:   org_y   <= cfg_mon.data[23:0];
          tqpb_pkg::CFG_U_STEP_X:   ustep_x <= cfg_mon.data[31:0];
          tqpb_pkg::CFG_U_STEP_Y:   ustep_y <= cfg_mon.data[31:0];
          tqpb_pkg::CFG_V_STEP_X:   vstep_x <= cfg_mon.data[31:0];
          tqpb_pkg::CFG_V_STEP_Y:   vstep_y <= cfg_mon.data[31:0];
          tqpb_pkg::CFG_TINT_RGB:   tint_c  <= cfg_mon.data[47:0];
          tqpb_pkg::CFG_TINT_ALPHA: tint_a  <= cfg_mon.data[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.req_type) begin
          tex_mem[in_mon.texel_index] = in_mon.texel_value;
        end else begin
          shade_q.push_back(shade(in_mon.screen_x, in_mon.screen_y, in_mon.dest_pixel));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (shade_q.size() == 0) begin
          $error("result with no pixel pending: out_pixel %h covered %b",
                 out_mon.out_pixel, out_mon.covered);
          fails = fails + 1;
        end else begin
          shade_res_t e;
          e = shade_q.pop_front();
          if (out_mon.covered !== e.covered) begin
            $error("covered: expected %b actual %b", e.covered, out_mon.covered);
            fails = fails + 1;
          end
          if (out_mon.out_pixel !== e.pixel) begin
            $error("out_pixel: expected %h actual %h", e.pixel, out_mon.out_pixel);
            fails = fails + 1;
          end
        end
      end
    end
  end

endmodule

/* bench/tb_textured_quad_pixel_blend.sv */
// ----------------------------------------------------------------------------
// tb_textured_quad_pixel_blend
// Drives texel writes, shade requests and register writes into the textured
// quad pixel blend block under random stalls on both sides and several quad
// settings, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_textured_quad_pixel_blend;

  localparam int NUM_PHASES   = 13;
  localparam int PHASE_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   snd_idle = 0;
  int   rcv_idle = 0;
  int   fails, pending;
  int   quiet_cycles = 0;
  int   org_px, org_py, quad_w;

  tqpb_pix_in_if  in_chan ();
  tqpb_pix_out_if out_chan ();
  tqpb_cfg_if     cfg_chan ();

  textured_quad_pixel_blend i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan),
    .cfg_chan_i (cfg_chan)
  );

  tqpb_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .cfg_mon      (cfg_chan),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_chan.valid       = 1'b0;
    in_chan.req_type    = 1'b0;
    in_chan.screen_x    = '0;
    in_chan.screen_y    = '0;
    in_chan.dest_pixel  = '0;
    in_chan.texel_index = '0;
    in_chan.texel_value = '0;
    out_chan.ready      = 1'b0;
    cfg_chan.valid      = 1'b0;
    cfg_chan.index      = tqpb_pkg::CFG_ORIGIN_X;
    cfg_chan.data       = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_chan.ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  // watchdog on cycles with no item moving on any channel
  always @(posedge clk_i) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(logic typ, logic [11:0] sx, logic [11:0] sy, logic [31:0] dest,
                      logic [11:0] idx, logic [31:0] val);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_chan.valid       <= 1'b1;
    in_chan.req_type    <= typ;
    in_chan.screen_x    <= sx;
    in_chan.screen_y    <= sy;
    in_chan.dest_pixel  <= dest;
    in_chan.texel_index <= idx;
    in_chan.texel_value <= val;
    do @(posedge clk_i); while (!in_chan.ready);
  endtask

  task automatic shade_px(logic [11:0] sx, logic [11:0] sy, logic [31:0] dest);
    send(1'b0, sx, sy, dest, 12'($urandom), $urandom);
  endtask

  task automatic write_reg(tqpb_pkg::cfg_idx_e idx, logic [47:0] data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    do @(posedge clk_i); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // square quad of quad_w pixels, axis-aligned when skew is zero, origin in whole pixels
  task automatic set_quad(int ox, int oy, int w, int skew);
    org_px = ox;
    org_py = oy;
    quad_w = w;
    write_reg(tqpb_pkg::CFG_ORIGIN_X, 48'(ox * 256));
    write_reg(tqpb_pkg::CFG_ORIGIN_Y, 48'(oy * 256));
    write_reg(tqpb_pkg::CFG_U_STEP_X, 48'((1 << 24) / w));
    write_reg(tqpb_pkg::CFG_U_STEP_Y, 48'(skew));
    write_reg(tqpb_pkg::CFG_V_STEP_X, 48'(-skew));
    write_reg(tqpb_pkg::CFG_V_STEP_Y, 48'((1 << 24) / w));
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [11:0] near(int o);
    return 12'(o + $urandom_range(0, quad_w + 3) - 2);
  endfunction

  initial begin
    int ph;
    int r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // whole texture first, so every sample reads a written texel
    for (int i = 0; i < tqpb_pkg::STORE_DEPTH; i++) send(1'b1, 0, 0, 0, 12'(i), $urandom);
    wait_idle();

    // directed corners of a 64 pixel quad at (100,100)
    set_quad(100, 100, 64, 0);
    send(1'b1, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 12'd0, 32'hFFFF_FFFF);
    send(1'b1, 12'h0, 12'h0, 32'h0, 12'd4095, 32'h0);
    send(1'b1, 0, 0, 0, 12'(6500 % 4096), 32'h80FF_0080);
    shade_px(100, 100, 32'h0);
    shade_px(164, 100, 32'hFFFF_FFFF);
    shade_px(100, 163, 32'h8040_C020);
    shade_px(164, 163, 32'h0);
    shade_px(164, 164, 32'h1234_5678);
    shade_px(100, 164, 32'hFFFF_FFFF);
    shade_px(99, 100, 32'hA5A5_A5A5);
    shade_px(165, 100, 32'h5A5A_5A5A);
    shade_px(0, 0, 32'h0);
    shade_px(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    shade_px(132, 132, 32'h7F80_8081);
    wait_idle();
    write_reg(tqpb_pkg::CFG_TINT_RGB, 48'h0);
    write_reg(tqpb_pkg::CFG_TINT_ALPHA, 16'h0);
    shade_px(120, 120, 32'hFFFF_FFFF);
    shade_px(101, 150, 32'h0);
    wait_idle();
    write_reg(tqpb_pkg::CFG_TINT_RGB, 48'hFFFF_0000_8000);
    write_reg(tqpb_pkg::CFG_TINT_ALPHA, 16'h8000);
    shade_px(110, 140, 32'hFF00_FF00);
    shade_px(150, 105, 32'h00FF_00FF);
    wait_idle();
    write_reg(tqpb_pkg::cfg_idx_e'(4'd9), 48'hFFFF_FFFF_FFFF);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      if (ph < 5) begin
        snd_idle = 27;
        rcv_idle = 73;
      end else if (ph < 10) begin
        snd_idle = 73;
        rcv_idle = 27;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      r = $urandom_range(0, 9);
      if (ph == 3) begin
        org_px = 0;
        org_py = 0;
        quad_w = 8;
        write_reg(tqpb_pkg::CFG_ORIGIN_X, 48'h7F_FFFF);
        write_reg(tqpb_pkg::CFG_ORIGIN_Y, 48'h80_0000);
        write_reg(tqpb_pkg::CFG_U_STEP_X, 48'h7FFF_FFFF);
        write_reg(tqpb_pkg::CFG_U_STEP_Y, 48'h8000_0000);
        write_reg(tqpb_pkg::CFG_V_STEP_X, 48'h8000_0000);
        write_reg(tqpb_pkg::CFG_V_STEP_Y, 48'h7FFF_FFFF);
      end else if (ph == 7) begin
        // far corner of the screen with a tiny quad
        set_quad(4090, 4090, 3, 0);
      end else begin
        set_quad($urandom_range(0, 4000), $urandom_range(0, 4000),
                 $urandom_range(2, 200), (r < 4) ? $urandom_range(0, 1 << 20) - (1 << 19) : 0);
      end
      case (ph % 4)
        0: write_reg(tqpb_pkg::CFG_TINT_RGB, 48'hFFFF_FFFF_FFFF);
        1: write_reg(tqpb_pkg::CFG_TINT_RGB, 48'h0);
        default: write_reg(tqpb_pkg::CFG_TINT_RGB, {$urandom, $urandom});
      endcase
      case (ph % 3)
        0: write_reg(tqpb_pkg::CFG_TINT_ALPHA, 16'hFFFF);
        1: write_reg(tqpb_pkg::CFG_TINT_ALPHA, 16'h0);
        default: write_reg(tqpb_pkg::CFG_TINT_ALPHA, 16'($urandom));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          send(1'b1, 12'($urandom), 12'($urandom), $urandom, 12'($urandom), rand_pixel());
        end else if (r < 85) begin
          shade_px(near(org_px), near(org_py), rand_pixel());
        end else begin
          shade_px(12'($urandom), 12'($urandom), rand_pixel());
        end
        // stretches with no sender gaps
        if (snd_idle != 0 && n == PHASE_ITEMS / 2) snd_idle = 0;
      end
    end

    in_chan.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
